// ===== hdl/hbtd_pkg.sv =====
package hbtd_pkg;

  localparam int unsigned NODE_CAPACITY = 512;
  localparam int unsigned STACK_DEPTH   = 256;

  // node index, node count (holds the capacity itself), stack slot, stack pointer
  localparam int unsigned NODE_AW  = $clog2(NODE_CAPACITY);
  localparam int unsigned NODE_CW  = $clog2(NODE_CAPACITY + 1);
  localparam int unsigned STACK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned STACK_PW = $clog2(STACK_DEPTH + 1);

  localparam int unsigned SYM_W = 8;

  typedef enum logic {
    OP_TREE = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  // One child link as kept in its parent: index plus the child's own leaf flag and symbol,
  // so a walk step needs only the current node's entry.
  typedef struct packed {
    logic [NODE_AW-1:0] idx;
    logic               leaf;
    logic [SYM_W-1:0]   sym;
  } child_t;

  localparam int unsigned CHILD_W = $bits(child_t);

endpackage

// ===== hdl/hbtd_ram.sv =====
module hbtd_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 18
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-through: a read of the word being written returns the new word
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hbtd_obuf.sv =====
module hbtd_obuf
  import hbtd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [SYM_W-1:0] data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SYM_W-1:0] out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [SYM_W-1:0] out_q, out_d;
  logic [SYM_W-1:0] skid_q, skid_d;
  logic             take;

  assign take = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        // output stalled: park the word
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/huffman_bitwise_tree_decoder_core.sv =====
// Channel   Handshake                  Word
// input     in_valid_i / in_ready_o    op_i, is_leaf_i, symbol_i, bit_req_i
// output    out_valid_o / out_ready_i  symbol_out_o
//
// One word per cycle in while in_ready_o is high; every word is finished in the cycle it is
// taken, and a decoded byte is registered in the output stage before it shows on the output.
// The stack RAM and the two node-link RAMs are read ahead, at the address
// the next word will need (entry below the stack top, current tree node).
// Reset clears counters, walk position and the output stage; the RAMs need no clearing.
// in_ready_o drops only while the output register and its skid stage both hold bytes.
module huffman_bitwise_tree_decoder_core
  import hbtd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic             is_leaf_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             bit_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SYM_W-1:0] symbol_out_o
);

  logic [NODE_CW-1:0]  count_q, count_d;
  logic [STACK_PW-1:0] sp_q, sp_d;
  logic                complete_q, complete_d;
  logic [NODE_AW-1:0]  cur_q, cur_d;
  logic [NODE_AW-1:0]  top_q, top_d;
  logic                top_left_done_q, top_left_done_d;
  logic                root_leaf_q, root_leaf_d;
  logic [SYM_W-1:0]    root_sym_q, root_sym_d;

  logic                accept;
  logic                obuf_full;
  logic                emit;
  logic [SYM_W-1:0]    emit_sym;

  logic [NODE_CW-1:0]  n;
  logic [STACK_PW-1:0] sp;
  logic [STACK_PW-1:0] sp1;
  logic [STACK_PW-1:0] sp_new;
  logic                pop;

  logic                lwe, rwe, swe;
  logic [NODE_AW-1:0]  node_waddr;
  child_t              node_wdata;
  logic [STACK_AW-1:0] stk_waddr;
  logic [NODE_AW-1:0]  stk_wdata;
  logic [STACK_AW-1:0] stk_raddr;
  logic [NODE_AW-1:0]  below;
  child_t              lrd, rrd, child;

  assign in_ready_o = !obuf_full;
  assign accept     = in_valid_i & in_ready_o;

  // a tree word after completion starts over from node 0
  assign n  = complete_q ? '0 : count_q;
  assign sp = complete_q ? '0 : sp_q;

  always_comb begin
    count_d         = count_q;
    sp_d            = sp_q;
    complete_d      = complete_q;
    cur_d           = cur_q;
    top_d           = top_q;
    top_left_done_d = top_left_done_q;
    root_leaf_d     = root_leaf_q;
    root_sym_d      = root_sym_q;
    lwe             = 1'b0;
    rwe             = 1'b0;
    swe             = 1'b0;
    node_waddr      = top_q;
    node_wdata      = '{idx: n[NODE_AW-1:0], leaf: is_leaf_i, sym: symbol_i};
    stk_waddr       = '0;
    stk_wdata       = top_q;
    emit            = 1'b0;
    emit_sym        = '0;
    pop             = (n != '0) && top_left_done_q;
    sp1             = sp - STACK_PW'(pop);
    sp_new          = sp1;
    child           = bit_req_i ? rrd : lrd;

    if (accept && (op_i == OP_TREE)) begin
      if (complete_q) begin
        count_d    = '0;
        sp_d       = '0;
        complete_d = 1'b0;
        cur_d      = '0;
      end
      // drop when out of nodes, or when an internal node finds the stack full
      if ((n < NODE_CW'(NODE_CAPACITY)) &&
          !(!is_leaf_i && (sp1 >= STACK_PW'(STACK_DEPTH)))) begin
        if (n == '0) begin
          root_leaf_d = is_leaf_i;
          root_sym_d  = symbol_i;
        end else if (pop) begin
          rwe = 1'b1;
        end else begin
          lwe = 1'b1;
        end
        if (!is_leaf_i) begin
          // spill the old top below; after a pop it is already there
          if (!pop && (sp1 != '0)) begin
            swe       = 1'b1;
            stk_waddr = STACK_AW'(sp1 - STACK_PW'(1));
          end
          top_d           = n[NODE_AW-1:0];
          top_left_done_d = 1'b0;
          sp_new          = sp1 + STACK_PW'(1);
        end else begin
          if (pop) begin
            top_d = below;
          end
          top_left_done_d = 1'b1;
          sp_new          = sp1;
        end
        sp_d       = sp_new;
        count_d    = n + NODE_CW'(1);
        complete_d = (sp_new == '0);
      end
    end else if (accept && (op_i == OP_DATA) && complete_q) begin
      if (root_leaf_q) begin
        emit     = 1'b1;
        emit_sym = root_sym_q;
        cur_d    = '0;
      end else if (child.leaf) begin
        emit     = 1'b1;
        emit_sym = child.sym;
        cur_d    = '0;
      end else begin
        cur_d = child.idx;
      end
    end
  end

  // prefetch the entry just below the next stack top
  assign stk_raddr = STACK_AW'(sp_d - STACK_PW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      sp_q            <= '0;
      complete_q      <= 1'b0;
      cur_q           <= '0;
      top_left_done_q <= 1'b0;
    end else begin
      count_q         <= count_d;
      sp_q            <= sp_d;
      complete_q      <= complete_d;
      cur_q           <= cur_d;
      top_left_done_q <= top_left_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    root_leaf_q <= root_leaf_d;
    root_sym_q  <= root_sym_d;
  end

  hbtd_ram #(
    .DEPTH (NODE_CAPACITY),
    .WIDTH (CHILD_W)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (cur_d),
    .rdata_o (lrd)
  );

  hbtd_ram #(
    .DEPTH (NODE_CAPACITY),
    .WIDTH (CHILD_W)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (rwe),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (cur_d),
    .rdata_o (rrd)
  );

  hbtd_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (NODE_AW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (below)
  );

  hbtd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .data_i      (emit_sym),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (symbol_out_o)
  );

`ifndef NO_ASSERTIONS
  a_complete_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> (sp_q == '0))
    else $error("tree complete with a non-empty build stack");

  a_walk_waits_for_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !complete_q |-> (cur_q == '0))
    else $error("walk position left the root before the tree was complete");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NODE_CW'(NODE_CAPACITY))
    else $error("node count beyond capacity");

  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output word pending");
`endif

endmodule

// ===== verif/tb_huffman_bitwise_tree_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_huffman_bitwise_tree_decoder_core;
  import hbtd_pkg::*;

  // Tracks the rebuilt code tree and the walk position, and holds the bytes still due.
  class symbol_scoreboard;
    bit                  node_leaf [NODE_CAPACITY];
    bit [SYM_W-1:0]      node_sym  [NODE_CAPACITY];
    bit [NODE_AW-1:0]    left_of   [NODE_CAPACITY];
    bit [NODE_AW-1:0]    right_of  [NODE_CAPACITY];
    bit [NODE_AW-1:0]    open_nodes [STACK_DEPTH];
    bit [STACK_PW-1:0]   open_cnt;
    bit [NODE_CW-1:0]    node_cnt;
    bit                  tree_done;
    bit [NODE_AW-1:0]    walk_pos;
    logic [SYM_W-1:0]    expected_syms [$];
    int                  failures;

    function new();
      open_cnt  = '0;
      node_cnt  = '0;
      tree_done = 1'b0;
      walk_pos  = '0;
      failures  = 0;
    endfunction

    function void add_tree_token(bit leaf, bit [SYM_W-1:0] sym);
      bit [NODE_AW-1:0]  n;
      bit [NODE_AW-1:0]  parent;
      bit [STACK_PW-1:0] sp;
      bit                pop;
      if (tree_done) begin
        node_cnt  = '0;
        open_cnt  = '0;
        tree_done = 1'b0;
        walk_pos  = '0;
      end
      if (node_cnt >= NODE_CAPACITY) return;
      n      = node_cnt[NODE_AW-1:0];
      sp     = open_cnt;
      pop    = 1'b0;
      parent = '0;
      if (node_cnt != 0) begin
        parent = open_nodes[sp - 1'b1];
        // left already taken: this node fills the right slot and closes the parent
        if (left_of[parent] != 0) begin
          pop = 1'b1;
          sp  = sp - 1'b1;
        end
      end
      if (!leaf && sp >= STACK_DEPTH) return;
      node_leaf[n] = leaf;
      node_sym[n]  = sym;
      left_of[n]   = '0;
      right_of[n]  = '0;
      if (node_cnt != 0) begin
        if (pop) right_of[parent] = n;
        else     left_of[parent]  = n;
      end
      if (!leaf) begin
        open_nodes[sp[STACK_AW-1:0]] = n;
        sp = sp + 1'b1;
      end
      open_cnt = sp;
      node_cnt = node_cnt + 1'b1;
      if (sp == 0) tree_done = 1'b1;
    endfunction

    function void walk_bit(bit dir);
      bit [NODE_AW-1:0] nxt;
      if (!tree_done) return;
      if (node_leaf[0]) begin
        walk_pos = '0;
        expected_syms.push_back(node_sym[0]);
        return;
      end
      nxt = dir ? right_of[walk_pos] : left_of[walk_pos];
      if (node_leaf[nxt]) begin
        walk_pos = '0;
        expected_syms.push_back(node_sym[nxt]);
      end else begin
        walk_pos = nxt;
      end
    endfunction

    function void note_word(op_e op, bit leaf, bit [SYM_W-1:0] sym, bit dir);
      if (op == OP_TREE) add_tree_token(leaf, sym);
      else walk_bit(dir);
    endfunction

    function void check_byte(logic [SYM_W-1:0] got);
      logic [SYM_W-1:0] want;
      if (expected_syms.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected decoded byte 0x%02h", got);
        return;
      end
      want = expected_syms.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("decoded byte mismatch: expected 0x%02h, got 0x%02h", want, got);
      end
    endfunction

    function int pending();
      return expected_syms.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             op_i;
  logic             is_leaf_i;
  logic [SYM_W-1:0] symbol_i;
  logic             bit_req_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [SYM_W-1:0] symbol_out_o;

  symbol_scoreboard sb = new();
  bit               send_quiet;
  bit               recv_quiet;

  huffman_bitwise_tree_decoder_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .is_leaf_i    (is_leaf_i),
    .symbol_i     (symbol_i),
    .bit_req_i    (bit_req_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .symbol_out_o (symbol_out_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_word(op_e'(op_i), is_leaf_i, symbol_i, bit_req_i);
      if (out_valid_o && out_ready_i)
        sb.check_byte(symbol_out_o);
    end
  end

  // Offer one word; entered and left at a falling edge.
  task automatic send_word(op_e op, bit leaf, bit [SYM_W-1:0] sym, bit dir);
    int gap;
    if ($urandom_range(0, 63) == 0) send_quiet = ~send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    is_leaf_i  <= leaf;
    symbol_i   <= sym;
    bit_req_i  <= dir;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_token(bit leaf, bit [SYM_W-1:0] sym);
    send_word(OP_TREE, leaf, sym, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_bit(bit dir);
    send_word(OP_DATA, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), dir);
  endtask

  // Emit a random well-formed preorder tree; optionally slip data bits in mid-build.
  task automatic send_random_tree(int max_internal, bit broken);
    int open_slots;
    int internal_left;
    bit first;
    open_slots    = 1;
    internal_left = max_internal;
    first         = 1'b1;
    while (open_slots > 0) begin
      if (broken && !first && $urandom_range(0, 4) == 0) send_bit(1'($urandom_range(0, 1)));
      if (internal_left > 0 && (first || $urandom_range(0, 1) == 1)) begin
        send_token(1'b0, 8'($urandom_range(0, 255)));
        open_slots++;
        internal_left--;
      end else begin
        send_token(1'b1, 8'($urandom_range(0, 255)));
        open_slots--;
      end
      first = 1'b0;
    end
  endtask

  // Receiver: random stalls per word, plus long hold-offs to back up the block.
  initial begin
    int stall;
    int taken;
    out_ready_i = 1'b0;
    recv_quiet  = 1'b0;
    taken       = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_quiet = ~recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 17);
      if (taken == 25 || taken == 250) stall = 300;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    int sent;
    int cap;
    int waited;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = OP_TREE;
    is_leaf_i  = 1'b0;
    symbol_i   = '0;
    bit_req_i  = 1'b0;
    send_quiet = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // data with no tree yet: dropped
    send_word(OP_DATA, 1'b0, 8'h00, 1'b0);
    send_word(OP_DATA, 1'b1, 8'hFF, 1'b1);
    // single-leaf trees emit on every bit
    send_word(OP_TREE, 1'b1, 8'h00, 1'b0);
    send_word(OP_DATA, 1'b1, 8'hFF, 1'b0);
    send_word(OP_DATA, 1'b0, 8'h00, 1'b1);
    send_word(OP_TREE, 1'b1, 8'hFF, 1'b1);
    send_bit(1'b1);
    // three-leaf tree, with a data bit mid-build that must be dropped
    send_word(OP_TREE, 1'b0, 8'hA5, 1'b0);
    send_word(OP_TREE, 1'b1, 8'h00, 1'b1);
    send_word(OP_TREE, 1'b0, 8'h5A, 1'b1);
    send_bit(1'b1);
    send_word(OP_TREE, 1'b1, 8'h81, 1'b0);
    send_word(OP_TREE, 1'b1, 8'hFF, 1'b0);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);

    sent = 0;
    while (sent < 800) begin
      if ($urandom_range(0, 9) == 0) cap = 0;
      else if ($urandom_range(0, 9) == 0) cap = $urandom_range(20, 150);
      else cap = $urandom_range(1, 12);
      send_random_tree(cap, $urandom_range(0, 5) == 0);
      repeat ($urandom_range(5, 60)) begin
        send_bit(1'($urandom_range(0, 1)));
        sent++;
      end
      sent += cap;
    end

    // Deep spine fills the build stack; the tree then runs out of node space for good.
    repeat (256) send_token(1'b0, 8'($urandom_range(0, 255)));
    repeat (2) send_token(1'b0, 8'($urandom_range(0, 255)));
    repeat (258) send_token(1'b1, 8'($urandom_range(0, 255)));
    send_token(1'b0, 8'($urandom_range(0, 255)));
    repeat (10) send_bit(1'($urandom_range(0, 1)));
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) $display("%0d decoded bytes never arrived", sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== huffman_bitwise_tree_decoder_core.f =====
hdl/hbtd_pkg.sv
hdl/hbtd_ram.sv
hdl/hbtd_obuf.sv
hdl/huffman_bitwise_tree_decoder_core.sv
verif/tb_huffman_bitwise_tree_decoder_core.sv
